// ===== rtl/life_grid_generation_step_unit_defines.svh =====
// Assertion helpers shared by the grid step unit.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LGS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lgs: same-cycle check failed");

// Next-cycle implication.
`define LGS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lgs: next-cycle check failed");

`endif

// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

  localparam int ACTION_W = 2;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int POP_W    = 13;
  localparam logic [POP_W-1:0] POP_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  // Neighborhood of the cell under evaluation plus its column edge flags.
  typedef struct packed {
    logic nw;
    logic n;
    logic ne;
    logic w;
    logic ctr;
    logic e;
    logic sw;
    logic s;
    logic se;
    logic at_left;
    logic at_right;
  } window_t;

endpackage

// ===== rtl/lgs_ram.sv =====
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lgs_cell.sv =====
module lgs_cell (
  input  logic clk_i,
  input  logic clr_i,
  input  logic en_i,
  input  logic d_i,
  output logic q_o
);

  logic bit_q;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      bit_q <= 1'b0;
    end else if (en_i) begin
      bit_q <= d_i;
    end
  end

  assign q_o = bit_q;

endmodule

// ===== rtl/lgs_rule.sv =====
module lgs_rule (
  input  lgs_pkg::window_t win_i,
  output logic             alive_o
);
  import lgs_pkg::*;

  logic       nw, w, sw, ne, e, se;
  logic [3:0] count;

  always_comb begin
    // Cells beyond the left or right border count as dead.
    nw = win_i.nw & ~win_i.at_left;
    w  = win_i.w  & ~win_i.at_left;
    sw = win_i.sw & ~win_i.at_left;
    ne = win_i.ne & ~win_i.at_right;
    e  = win_i.e  & ~win_i.at_right;
    se = win_i.se & ~win_i.at_right;
    count = {3'b000, nw} + {3'b000, win_i.n} + {3'b000, ne} + {3'b000, w}
          + {3'b000, e} + {3'b000, sw} + {3'b000, win_i.s} + {3'b000, se};
    alive_o = (count == 4'd3) || (win_i.ctr && (count == 4'd2));
  end

endmodule

// ===== rtl/life_grid_generation_step_unit.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | action_i, row_i, col_i, cell_value_i
// out     | output    | out_valid_o / out_ready_i| cell_out_o, population_o
//
// Every item gives one result. A write goes through ST_EMIT to the output register, a read
// through ST_READ and then ST_EMIT. A step streams the current plane once through a chain
// of 2*COLS+3 shift cells, one cell per cycle. After reset both planes are swept to dead,
// every address in turn, before in_ready_o rises.
// One item is in work at a time; a result waiting in the output register does not stop the
// next item from being accepted, only from being delivered.
`include "life_grid_generation_step_unit_defines.svh"

module life_grid_generation_step_unit #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lgs_pkg::ACTION_W-1:0] action_i,
  input  logic [lgs_pkg::ROW_W-1:0]    row_i,
  input  logic [lgs_pkg::COL_W-1:0]    col_i,
  input  logic                         cell_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         cell_out_o,
  output logic [lgs_pkg::POP_W-1:0]    population_o
);
  import lgs_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int KEND  = CELLS + COLS + 1;
  localparam int KW    = $clog2(KEND + 1);
  localparam int CHAIN = 2 * COLS + 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [KW-1:0]    k_q;
  logic             p1_v_q, p1_zero_q, p1_ctr_q, p2_v_q;
  logic [AW-1:0]    m_addr_q;
  logic [CW-1:0]    m_col_q;
  logic [POP_W-1:0] pop_q;
  logic             front_q;
  logic             rd_inside_q;
  logic             res_cell_q;
  logic [POP_W-1:0] res_pop_q;
  logic             out_valid_q, cell_out_q;
  logic [POP_W-1:0] population_q;

  logic             accept, in_grid, wr_item, issue_v, step_done, alive, emit;
  logic [AW-1:0]    item_addr, raddr, waddr;
  logic             we_a, we_b, wdata, rdata_a, rdata_b, front_rdata, push_bit;
  logic [POP_W-1:0] pop_d;
  logic [CHAIN-1:0] chain;
  window_t          win;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_grid    = (int'(row_i) < ROWS) && (int'(col_i) < COLS);
  assign item_addr  = AW'(int'(row_i) * COLS + int'(col_i));
  assign wr_item    = accept && (action_i == ACT_WRITE) && in_grid;

  assign issue_v    = (state_q == ST_STEP) && (int'(k_q) != KEND);
  assign step_done  = p2_v_q && (int'(m_addr_q) == CELLS - 1);
  assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Plane A is the front plane when front_q is low.
  assign raddr = (state_q == ST_IDLE) ? item_addr : k_q[AW-1:0];
  always_comb begin
    if (state_q == ST_CLEAR) begin
      waddr = k_q[AW-1:0];
      wdata = 1'b0;
    end else if (p2_v_q) begin
      waddr = m_addr_q;
      wdata = alive;
    end else begin
      waddr = item_addr;
      wdata = cell_value_i;
    end
  end
  assign we_a = (state_q == ST_CLEAR) || (wr_item && !front_q) || (p2_v_q && front_q);
  assign we_b = (state_q == ST_CLEAR) || (wr_item && front_q) || (p2_v_q && !front_q);

  lgs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_plane_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  lgs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_plane_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  assign front_rdata = front_q ? rdata_b : rdata_a;
  // Past the last row the stream carries dead cells.
  assign push_bit    = p1_zero_q ? 1'b0 : front_rdata;

  // Raster-order shift chain; cleared at step start so rows above the grid read dead.
  for (genvar i = 0; i < CHAIN; i++) begin : g_chain
    if (i == 0) begin : g_head
      lgs_cell u_cell (
        .clk_i (clk_i),
        .clr_i (accept && (action_i == ACT_STEP)),
        .en_i  (p1_v_q),
        .d_i   (push_bit),
        .q_o   (chain[i])
      );
    end else begin : g_body
      lgs_cell u_cell (
        .clk_i (clk_i),
        .clr_i (accept && (action_i == ACT_STEP)),
        .en_i  (p1_v_q),
        .d_i   (chain[i-1]),
        .q_o   (chain[i])
      );
    end
  end

  always_comb begin
    win.se       = chain[0];
    win.s        = chain[1];
    win.sw       = chain[2];
    win.e        = chain[COLS];
    win.ctr      = chain[COLS+1];
    win.w        = chain[COLS+2];
    win.ne       = chain[2*COLS];
    win.n        = chain[2*COLS+1];
    win.nw       = chain[2*COLS+2];
    win.at_left  = (m_col_q == '0);
    win.at_right = (int'(m_col_q) == COLS - 1);
  end

  lgs_rule u_rule (
    .win_i   (win),
    .alive_o (alive)
  );

  assign pop_d = (alive && (pop_q != POP_MAX)) ? pop_q + 1'b1 : pop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      k_q          <= '0;
      p1_v_q       <= 1'b0;
      p1_zero_q    <= 1'b0;
      p1_ctr_q     <= 1'b0;
      p2_v_q       <= 1'b0;
      m_addr_q     <= '0;
      m_col_q      <= '0;
      pop_q        <= '0;
      front_q      <= 1'b0;
      rd_inside_q  <= 1'b0;
      res_cell_q   <= 1'b0;
      res_pop_q    <= '0;
      out_valid_q  <= 1'b0;
      cell_out_q   <= 1'b0;
      population_q <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      p1_v_q    <= issue_v;
      p1_zero_q <= (int'(k_q) >= CELLS);
      p1_ctr_q  <= (int'(k_q) >= COLS + 1);
      p2_v_q    <= p1_v_q && p1_ctr_q;
      if (issue_v) begin
        k_q <= k_q + 1'b1;
      end

      if (p2_v_q) begin
        m_addr_q <= m_addr_q + 1'b1;
        m_col_q  <= (int'(m_col_q) == COLS - 1) ? '0 : m_col_q + 1'b1;
        pop_q    <= pop_d;
      end

      case (state_q)
        ST_CLEAR: begin
          if (int'(k_q) == CELLS - 1) begin
            k_q     <= '0;
            state_q <= ST_IDLE;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_cell_q  <= 1'b0;
            res_pop_q   <= '0;
            rd_inside_q <= in_grid;
            case (action_i)
              ACT_READ: state_q <= ST_READ;
              ACT_STEP: begin
                k_q      <= '0;
                m_addr_q <= '0;
                m_col_q  <= '0;
                pop_q    <= '0;
                state_q  <= ST_STEP;
              end
              default:  state_q <= ST_EMIT;
            endcase
          end
        end
        ST_READ: begin
          res_cell_q <= rd_inside_q && front_rdata;
          state_q    <= ST_EMIT;
        end
        ST_STEP: begin
          if (step_done) begin
            front_q   <= ~front_q;
            res_pop_q <= pop_d;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            cell_out_q   <= res_cell_q;
            population_q <= res_pop_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_out_o   = cell_out_q;
  assign population_o = population_q;

  `LGS_ASSERT_NXT(a_one_item_in_work, accept, !in_ready_o)
  `LGS_ASSERT_IMP(a_result_fields_exclusive, out_valid_o && (population_o != '0), !cell_out_o)
  `LGS_ASSERT_NXT(a_front_flips_on_done_only, !step_done, front_q == $past(front_q))
  `LGS_ASSERT_IMP(a_eval_inside_step, p2_v_q, state_q == ST_STEP)

endmodule

// ===== sim/tb_life_grid_generation_step_unit.sv =====
module tb_life_grid_generation_step_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int GRID_ROWS = 1 << ROW_W;
  localparam int GRID_COLS = 1 << COL_W;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 110;
  localparam int WIN = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  // Tracks both cell planes and the front plane, and holds the cell/population
  // pairs that the block still owes.
  class life_grid_scoreboard;
    localparam int N_ROWS = 1 << ROW_W;
    localparam int N_COLS = 1 << COL_W;
    localparam int SURVIVE_MIN = 2;
    localparam int BIRTH_COUNT = 3;

    typedef struct {
      logic [ACTION_W-1:0] act;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic                cell_bit;
      logic [POP_W-1:0]    pop;
    } cell_pop_t;

    bit plane_q [2][N_ROWS][N_COLS];
    bit front_q;
    cell_pop_t cell_pop_q[$];
    int unsigned fail_count;

    function new();
      front_q = 1'b0;
      fail_count = 0;
    endfunction

    // Builds the next generation in the back plane, swaps, returns the population.
    function logic [POP_W-1:0] advance_generation();
      int unsigned born;
      int n, rr, cc;
      bit self_v, alive;
      born = 0;
      for (int r = 0; r < N_ROWS; r++) begin
        for (int c = 0; c < N_COLS; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < N_ROWS && cc >= 0 && cc < N_COLS)
                n += plane_q[front_q][rr][cc];
            end
          end
          self_v = plane_q[front_q][r][c];
          if (self_v)
            alive = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
          else
            alive = (n == BIRTH_COUNT);
          plane_q[!front_q][r][c] = alive;
          born += alive;
        end
      end
      front_q = !front_q;
      return (born > POP_MAX) ? POP_MAX : born[POP_W-1:0];
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic [ROW_W-1:0] row,
                            logic [COL_W-1:0] col, logic val);
      cell_pop_t e;
      bit on_grid;
      e.act = act;
      e.row = row;
      e.col = col;
      e.cell_bit = 1'b0;
      e.pop = '0;
      on_grid = (row < N_ROWS) && (col < N_COLS);
      case (act)
        ACT_WRITE: if (on_grid) plane_q[front_q][row][col] = val;
        ACT_READ:  if (on_grid) e.cell_bit = plane_q[front_q][row][col];
        ACT_STEP:  e.pop = advance_generation();
        default:   ;
      endcase
      cell_pop_q.push_back(e);
    endfunction

    task report(string msg);
      fail_count++;
      $display("[%0t] %s", $time, msg);
    endtask

    task check_result(logic cell_bit, logic [POP_W-1:0] pop);
      cell_pop_t e;
      if (cell_pop_q.size() == 0) begin
        report($sformatf("result with nothing pending: cell_out %0d population %0d",
                         cell_bit, pop));
      end else begin
        e = cell_pop_q.pop_front();
        if (cell_bit !== e.cell_bit)
          report($sformatf("action %0d at (%0d,%0d): cell_out %0d, predicted %0d",
                           e.act, e.row, e.col, cell_bit, e.cell_bit));
        if (pop !== e.pop)
          report($sformatf("action %0d at (%0d,%0d): population %0d, predicted %0d",
                           e.act, e.row, e.col, pop, e.pop));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i;
  logic [ROW_W-1:0]    row_i;
  logic [COL_W-1:0]    col_i;
  logic                cell_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                cell_out_o;
  logic [POP_W-1:0]    population_o;

  life_grid_scoreboard sb;
  bit send_quiet;
  bit recv_quiet;
  int unsigned items_sent;

  life_grid_generation_step_unit #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_value_i(cell_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_out_o  (cell_out_o),
    .population_o(population_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a clock edge; returns at the edge where the item is accepted.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic v);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    row_i        <= r;
    col_i        <= c;
    cell_value_i <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(act, r, c, v);
    items_sent++;
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(cell_out_o, population_o);
    end
  end

  initial begin
    int r0, c0, rr, cc, writes, steps, reads;
    int unsigned start_count;
    sb = new();
    items_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_WRITE;
    row_i = '0;
    col_i = '0;
    cell_value_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lone corner cells have no neighbors and must all die on the first step.
    send_item(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd0, 6'd63, 1'b1);
    send_item(ACT_WRITE, 6'd63, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd63, 6'd63, 1'b1);
    send_item(ACT_READ, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd63, 6'd63, 1'b0);
    send_item(ACT_UNUSED, 6'd63, 6'd63, 1'b1);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd0, 6'd63, 1'b0);
    // A blinker in the middle and a still block against the top-left corner.
    send_item(ACT_WRITE, 6'd31, 6'd30, 1'b1);
    send_item(ACT_WRITE, 6'd31, 6'd31, 1'b1);
    send_item(ACT_WRITE, 6'd31, 6'd32, 1'b1);
    send_item(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd1, 1'b1);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd30, 6'd31, 1'b0);
    send_item(ACT_READ, 6'd31, 6'd30, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_WRITE, 6'd31, 6'd31, 1'b0);
    send_item(ACT_READ, 6'd31, 6'd31, 1'b0);
    send_item(ACT_STEP, 6'd0, 6'd0, 1'b0);
    send_item(ACT_UNUSED, 6'd0, 6'd0, 1'b0);
    send_item(ACT_READ, 6'd1, 6'd1, 1'b0);

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // Seed a small window, often against an edge, then evolve and probe it.
        case ($urandom_range(0, 3))
          0:       r0 = 0;
          1:       r0 = GRID_ROWS - WIN;
          default: r0 = $urandom_range(0, GRID_ROWS - WIN);
        endcase
        case ($urandom_range(0, 3))
          0:       c0 = 0;
          1:       c0 = GRID_COLS - WIN;
          default: c0 = $urandom_range(0, GRID_COLS - WIN);
        endcase
        writes = $urandom_range(3, 10);
        repeat (writes)
          send_item(ACT_WRITE, 6'(r0 + $urandom_range(0, WIN - 1)),
                    6'(c0 + $urandom_range(0, WIN - 1)), $urandom_range(0, 99) < 65);
        steps = $urandom_range(1, 3);
        repeat (steps) begin
          send_item(ACT_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
          reads = $urandom_range(1, 3);
          repeat (reads) begin
            rr = r0 - 1 + $urandom_range(0, WIN + 1);
            cc = c0 - 1 + $urandom_range(0, WIN + 1);
            if (rr < 0) rr = 0;
            if (rr > GRID_ROWS - 1) rr = GRID_ROWS - 1;
            if (cc < 0) cc = 0;
            if (cc > GRID_COLS - 1) cc = GRID_COLS - 1;
            send_item(ACT_READ, 6'(rr), 6'(cc), 1'($urandom));
          end
        end
      end else begin
        send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.cell_pop_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== life_grid_generation_step_unit.f =====
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_ram.sv
rtl/lgs_cell.sv
rtl/lgs_rule.sv
rtl/life_grid_generation_step_unit.sv
sim/tb_life_grid_generation_step_unit.sv
